[design/mdk_pkg.sv]
// ----------------------------------------------------------------------------
// mdk_pkg
// Types and constants shared by the motor direction key controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mdk_pkg;

  localparam int DUTY_W = 7;
  localparam int LPT_W  = 16;
  localparam int DEB_W  = 8;
  localparam int DEAD_W = 8;

  localparam logic [DUTY_W-1:0] DUTY_FULL      = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_DIGIT_MIN = 7'd60;

  localparam logic [LPT_W-1:0]  LPT_RESET  = 16'd1000;
  localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd10;
  localparam logic [DEAD_W-1:0] DEAD_RESET = 8'd10;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;

  // Command characters.
  localparam logic [7:0] CH_DIGIT_LO = 8'h31;  // '1'
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;  // '9'
  localparam logic [7:0] CH_STOP_LC  = 8'h73;  // 's'
  localparam logic [7:0] CH_STOP_UC  = 8'h53;  // 'S'
  localparam logic [7:0] CH_FWD_LC   = 8'h66;  // 'f'
  localparam logic [7:0] CH_FWD_UC   = 8'h46;  // 'F'
  localparam logic [7:0] CH_REV_LC   = 8'h72;  // 'r'
  localparam logic [7:0] CH_REV_UC   = 8'h52;  // 'R'

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_DEAD       = 2'd2,
    REG_INIT_DUTY  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } motor_mode_t;

  typedef enum logic [2:0] {
    KM_IDLE     = 3'd0,
    KM_PRESSED  = 3'd1,
    KM_REL_DEB  = 3'd2,
    KM_WAIT_REL = 3'd3,
    KM_WAIT_DEB = 3'd4
  } key_mode_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       key_level;
  } mdk_item_t;

  typedef struct packed {
    logic              long_press;
    logic              short_press;
    logic [DUTY_W-1:0] speed_setting;
    logic [DUTY_W-1:0] drive_duty;
    logic [1:0]        drive_dir;
  } mdk_result_t;

endpackage

`default_nettype wire

[design/mdk_in_reg.sv]
// ----------------------------------------------------------------------------
// mdk_in_reg
// Input register: holds one accepted tick item until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mdk_in_reg
  import mdk_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mdk_item_t in_item,
  input  wire logic      consume,
  output logic           item_valid,
  output mdk_item_t      item
);

  logic      vld_r;
  logic      vld_nxt;
  mdk_item_t item_r;

  // A new word may enter whenever the register is empty or drains this cycle.
  assign in_ready = !vld_r || consume;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

`default_nettype wire

[design/mdk_core.sv]
// ----------------------------------------------------------------------------
// mdk_core
// Configuration registers, controller state and the per-tick update logic:
// byte command, latched press event, then the key debounce machine.
// ----------------------------------------------------------------------------
`default_nettype none

module mdk_core
  import mdk_pkg::*;
#(
  parameter int HOLD_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        step,
  input  wire mdk_item_t   item,
  output mdk_result_t      result
);

  localparam int CMP_W = (HOLD_COUNT_BITS > LPT_W) ? HOLD_COUNT_BITS : LPT_W;

  // Configuration.
  logic [LPT_W-1:0]  lpt_r;
  logic [DEB_W-1:0]  deb_ticks_r;
  logic [DEAD_W-1:0] dead_ticks_r;

  // Controller state.
  motor_mode_t          mode_r,   mode_nxt;
  logic [DUTY_W-1:0]    duty_r,   duty_nxt;
  logic [DUTY_W-1:0]    speed_r,  speed_nxt;
  logic [DEAD_W-1:0]    pause_r,  pause_nxt;
  key_mode_t            km_r,     km_nxt;
  logic [HOLD_COUNT_BITS-1:0] hold_r, hold_nxt;
  logic [DEB_W-1:0]     dcnt_r,   dcnt_nxt;
  logic                 short_r,  short_nxt;
  logic                 long_r,   long_nxt;
  logic                 prev_key_r;

  logic                 sp_set;
  logic                 lp_set;
  logic [HOLD_COUNT_BITS-1:0] hold_inc;
  logic [DEB_W-1:0]     dcnt_dec;
  logic                 hold_long;
  logic [DUTY_W-1:0]    cfg_duty;

  assign cfg_duty = (cfg_wdata[DUTY_W-1:0] > DUTY_FULL) ? DUTY_FULL : cfg_wdata[DUTY_W-1:0];

  // Saturating hold counter increment and long press compare.
  assign hold_inc  = (&hold_r) ? hold_r : hold_r + 1'b1;
  assign hold_long = CMP_W'(hold_inc) >= CMP_W'(lpt_r);
  assign dcnt_dec  = (dcnt_r != '0) ? dcnt_r - 1'b1 : dcnt_r;

  // Key machine: next state and counters.
  always_comb begin
    km_nxt   = km_r;
    hold_nxt = hold_r;
    dcnt_nxt = dcnt_r;
    sp_set   = 1'b0;
    lp_set   = 1'b0;
    unique case (km_r)
      KM_IDLE: begin
        if (item.key_level && !prev_key_r) begin
          hold_nxt = '0;
          km_nxt   = KM_PRESSED;
        end
      end
      KM_PRESSED: begin
        hold_nxt = hold_inc;
        if (hold_long) begin
          lp_set = 1'b1;
          km_nxt = KM_WAIT_REL;
        end else if (!item.key_level) begin
          if (deb_ticks_r == '0) begin
            sp_set = 1'b1;
            km_nxt = KM_IDLE;
          end else begin
            dcnt_nxt = deb_ticks_r;
            km_nxt   = KM_REL_DEB;
          end
        end
      end
      KM_REL_DEB: begin
        hold_nxt = hold_inc;
        if (item.key_level) begin
          km_nxt = KM_PRESSED;
        end else begin
          dcnt_nxt = dcnt_dec;
          if (dcnt_dec == '0) begin
            sp_set = 1'b1;
            km_nxt = KM_IDLE;
          end
        end
      end
      KM_WAIT_REL: begin
        if (!item.key_level) begin
          if (deb_ticks_r == '0) begin
            km_nxt = KM_IDLE;
          end else begin
            dcnt_nxt = deb_ticks_r;
            km_nxt   = KM_WAIT_DEB;
          end
        end
      end
      KM_WAIT_DEB: begin
        if (item.key_level) begin
          km_nxt = KM_WAIT_REL;
        end else begin
          dcnt_nxt = dcnt_dec;
          if (dcnt_dec == '0) begin
            km_nxt = KM_IDLE;
          end
        end
      end
      default: km_nxt = KM_IDLE;
    endcase
  end

  // Motor side: dead time, byte command, then the event latched last tick.
  always_comb begin
    logic [3:0] digit;
    mode_nxt  = mode_r;
    duty_nxt  = duty_r;
    speed_nxt = speed_r;
    pause_nxt = (pause_r != '0) ? pause_r - 1'b1 : pause_r;
    digit     = 4'(item.rx_byte - CH_DIGIT_LO);

    if (item.rx_valid) begin
      if (item.rx_byte >= CH_DIGIT_LO && item.rx_byte <= CH_DIGIT_HI && mode_r != MODE_STOP) begin
        // Duty steps of five percent: digit * 4 + digit.
        speed_nxt = DUTY_DIGIT_MIN + {1'b0, digit, 2'b00} + {3'b000, digit};
        duty_nxt  = speed_nxt;
      end else if (item.rx_byte == CH_STOP_LC || item.rx_byte == CH_STOP_UC) begin
        mode_nxt  = MODE_STOP;
        duty_nxt  = '0;
        pause_nxt = '0;
      end else if (item.rx_byte == CH_FWD_LC || item.rx_byte == CH_FWD_UC) begin
        mode_nxt  = MODE_FWD;
        duty_nxt  = DUTY_FULL;
        pause_nxt = dead_ticks_r;
      end else if (item.rx_byte == CH_REV_LC || item.rx_byte == CH_REV_UC) begin
        mode_nxt  = MODE_REV;
        duty_nxt  = DUTY_FULL;
        pause_nxt = dead_ticks_r;
      end
    end

    if (long_r) begin
      mode_nxt  = MODE_STOP;
      duty_nxt  = '0;
      pause_nxt = '0;
    end else if (short_r) begin
      duty_nxt = speed_nxt;
      if (mode_nxt == MODE_FWD) begin
        mode_nxt  = MODE_REV;
        pause_nxt = dead_ticks_r;
      end else if (mode_nxt == MODE_REV) begin
        mode_nxt  = MODE_FWD;
        pause_nxt = dead_ticks_r;
      end else begin
        mode_nxt  = MODE_FWD;
        pause_nxt = '0;
      end
    end

    // A short event waits behind a long one; new events come from the key machine.
    short_nxt = sp_set || (short_r && long_r);
    long_nxt  = lp_set;
  end

  // Result for this tick.
  always_comb begin
    if (mode_nxt == MODE_STOP || pause_nxt != '0) begin
      result.drive_dir  = 2'(MODE_STOP);
      result.drive_duty = '0;
    end else begin
      result.drive_dir  = 2'(mode_nxt);
      result.drive_duty = duty_nxt;
    end
    result.speed_setting = speed_nxt;
    result.short_press   = sp_set;
    result.long_press    = lp_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpt_r        <= LPT_RESET;
      deb_ticks_r  <= DEB_RESET;
      dead_ticks_r <= DEAD_RESET;
      mode_r       <= MODE_STOP;
      duty_r       <= '0;
      speed_r      <= DUTY_RESET;
      pause_r      <= '0;
      km_r         <= KM_IDLE;
      hold_r       <= '0;
      dcnt_r       <= '0;
      short_r      <= 1'b0;
      long_r       <= 1'b0;
      prev_key_r   <= 1'b0;
    end else begin
      if (step) begin
        mode_r     <= mode_nxt;
        duty_r     <= duty_nxt;
        pause_r    <= pause_nxt;
        km_r       <= km_nxt;
        hold_r     <= hold_nxt;
        dcnt_r     <= dcnt_nxt;
        short_r    <= short_nxt;
        long_r     <= long_nxt;
        prev_key_r <= item.key_level;
      end
      // A write to the initial duty register loads the stored speed, clamped to full duty.
      if (cfg_wr_en && reg_idx_t'(cfg_addr) == REG_INIT_DUTY) begin
        speed_r <= cfg_duty;
      end else if (step) begin
        speed_r <= speed_nxt;
      end
      if (cfg_wr_en) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_LONG_PRESS: lpt_r        <= cfg_wdata;
          REG_DEBOUNCE:   deb_ticks_r  <= cfg_wdata[DEB_W-1:0];
          REG_DEAD:       dead_ticks_r <= cfg_wdata[DEAD_W-1:0];
          REG_INIT_DUTY:  ;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[design/mdk_out_reg.sv]
// ----------------------------------------------------------------------------
// mdk_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mdk_out_reg
  import mdk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire mdk_result_t load_data,
  output logic             can_load,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mdk_result_t      out_data
);

  logic        vld_r;
  logic        vld_nxt;
  mdk_result_t data_r;

  assign can_load = !vld_r || out_ready;
  assign vld_nxt  = load || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[design/motor_direction_key_uart_controller_core.sv]
// ----------------------------------------------------------------------------
// motor_direction_key_uart_controller_core
// Per-tick motor direction controller driven by a push key and UART bytes.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word layout (lsb first)
//  --------+-----------+------------------------------------------------------
//  in_     | sink      | key_level, rx_valid, rx_byte[7:0], zero pad to 16 bits
//  out_    | source    | drive_dir[1:0], drive_duty[6:0], speed_setting[6:0],
//          |           | short_press, long_press, zero pad to 24 bits
//  cfg_    | write     | 0 long_press_ticks, 1 debounce_ticks, 2 dead_ticks,
//          |           | 3 initial_duty
//
// One tick word is accepted per clock while in_tready is high; its result word
// is registered in the input register, then through the update logic in the result
// register. The update logic processes the held word in the cycle the result
// register can load, so a stalled sink holds at most one word in each register.
// Reset is synchronous, active low, and restores valid flags, config and state to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_direction_key_uart_controller_core
  import mdk_pkg::*;
#(
  parameter int HOLD_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // key_level, rx_valid, rx_byte[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // drive_dir, drive_duty, speed_setting,
                                       // short_press, long_press
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  mdk_item_t   in_item;
  mdk_item_t   item;
  logic        item_valid;
  logic        can_load;
  logic        step;
  mdk_result_t result;
  mdk_result_t out_data;

  assign in_item = mdk_item_t'(in_tdata[$bits(mdk_item_t)-1:0]);
  assign step    = item_valid && can_load;

  mdk_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .consume    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  mdk_core #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  mdk_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .load_data (result),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {{(24 - $bits(mdk_result_t)){1'b0}}, out_data};

endmodule

`default_nettype wire
